>>> rtl/jspd_pkg.sv
// shared types, constants and report decode for the joystick serial packet decoder
package jspd_pkg;

  localparam int BUFFER_BYTES = 4;
  localparam int BUF_IDX_W    = $clog2(BUFFER_BYTES);
  localparam int FILL_W       = $clog2(BUFFER_BYTES + 1);
  localparam int LEN_W        = 3;
  localparam int NUM_TYPES    = 8;
  localparam int LENGTHS_W    = LEN_W * NUM_TYPES;

  localparam logic [LENGTHS_W-1:0] LENGTHS_RESET = 24'h020620;

  // configuration port
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] REG_PACKET_LENGTHS = 1'b0;

  // output queue
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // packet types
  localparam logic [2:0] TYPE_BUTTONS = 3'd1;
  localparam logic [2:0] TYPE_STICK   = 3'd3;
  localparam logic [2:0] TYPE_ANALOG  = 3'd5;

  // report kinds
  localparam logic [1:0] KIND_BUTTONS = 2'd0;
  localparam logic [1:0] KIND_STICK   = 2'd1;
  localparam logic [1:0] KIND_ANALOG  = 2'd2;
  localparam logic [1:0] KIND_EMPTY   = 2'd3;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        buttons;
    logic signed [9:0] stick_x;
    logic signed [8:0] stick_y;
    logic signed [8:0] throttle;
    logic signed [1:0] hat_x;
    logic signed [1:0] hat_y;
    logic signed [8:0] dial_delta;
    logic              last;
  } report_t;

  // clamped packet length for a type
  function automatic logic [FILL_W-1:0] length_for_type(logic [LENGTHS_W-1:0] lengths,
                                                         logic [2:0] ptype);
    logic [LEN_W-1:0] n;
    n = lengths[LEN_W*ptype +: LEN_W];
    if (n > LEN_W'(BUFFER_BYTES)) begin
      length_for_type = FILL_W'(BUFFER_BYTES);
    end else begin
      length_for_type = FILL_W'(n);
    end
  endfunction

  function automatic report_t decode_report(logic [7:0] b0, logic [7:0] b1,
                                            logic [7:0] b2, logic [7:0] b3);
    report_t r;
    logic [2:0] ptype;
    r     = '0;
    ptype = b0[6:4];
    unique case (ptype)
      TYPE_BUTTONS: begin
        r.kind    = KIND_BUTTONS;
        r.buttons = b3[3:0];
      end
      TYPE_STICK: begin
        r.kind    = KIND_STICK;
        r.stick_x = {1'b0, b0[3], 8'b0} - {2'b0, b2[7] | b0[2], b2[6:0]};
        r.stick_y = {1'b0, b1[7] | b0[0], b1[6:0]} - {b0[1], 8'b0};
      end
      TYPE_ANALOG: begin
        r.kind       = KIND_ANALOG;
        r.throttle   = {1'b0, b1[7] | b0[0], b1[6:0]} - {b0[1], 8'b0};
        r.hat_x      = {1'b0, b3[1]} - {1'b0, b3[0]};
        r.hat_y      = {1'b0, b3[3]} - {1'b0, b3[2]};
        r.dial_delta = {1'b0, b2[7] | b0[2], b2[6:0]} - {b0[3], 8'b0};
      end
      default: begin
        r.kind = KIND_EMPTY;
      end
    endcase
    decode_report = r;
  endfunction

endpackage

>>> rtl/joystick_serial_packet_decoder.sv
// joystick serial packet decoder: byte assembly, report decode and output queue
// a report is written into the output queue at the edge that accepts its completing byte
// throughput: one byte per cycle when not stalled; a byte yields zero, one or two reports
// reports leave a 4-entry queue, one per cycle unless rpt_stall_i is high; rx_stall_o rises
//   when under two entries are free, so a run of two-report bytes is paced by the output side
// reset: buffer cleared to zero, no packet open, queue empty, lengths register at 0x020620
module joystick_serial_packet_decoder (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // configuration
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [jspd_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [jspd_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [jspd_pkg::CFG_DATA_W-1:0] prdata,
  output logic                            pready,
  // byte input
  input  logic                            rx_valid_i,
  output logic                            rx_stall_o,
  input  logic [7:0]                      rx_byte_i,
  // report output
  output logic                            rpt_valid_o,
  input  logic                            rpt_stall_i,
  output logic [1:0]                      report_kind_o,
  output logic [3:0]                      buttons_o,
  output logic signed [9:0]               stick_x_o,
  output logic signed [8:0]               stick_y_o,
  output logic signed [8:0]               throttle_o,
  output logic signed [1:0]               hat_x_o,
  output logic signed [1:0]               hat_y_o,
  output logic signed [8:0]               dial_delta_o,
  output logic                            last_of_run_o
);
  import jspd_pkg::*;

  logic [LENGTHS_W-1:0] lengths_q;
  logic [7:0]           buf_q [BUFFER_BYTES];
  logic [7:0]           buf_d [BUFFER_BYTES];
  logic [FILL_W-1:0]    fill_q, fill_d;
  logic [FILL_W-1:0]    exp_q, exp_d;

  report_t              queue_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]    wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]    count_q, count_d;

  logic    cfg_wr, rx_acc, rpt_acc;
  logic    emit_partial, emit_full;
  report_t rep_partial, rep_full, rep_first;
  logic [QCNT_W-1:0] push_n;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == REG_PACKET_LENGTHS);

  always_comb begin
    prdata = '0;
    if (paddr[2] == REG_PACKET_LENGTHS) begin
      prdata = CFG_DATA_W'(lengths_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lengths_q <= LENGTHS_RESET;
    end else if (cfg_wr) begin
      lengths_q <= pwdata[LENGTHS_W-1:0];
    end
  end

  assign rx_acc  = rx_valid_i & ~rx_stall_o;
  assign rpt_acc = rpt_valid_o & ~rpt_stall_i;

  // packet assembly
  always_comb begin
    logic [FILL_W-1:0] fill_v, exp_v;
    fill_v       = fill_q;
    exp_v        = exp_q;
    buf_d        = buf_q;
    emit_partial = 1'b0;
    emit_full    = 1'b0;
    // a start byte closes any open packet first
    if (rx_byte_i[7]) begin
      emit_partial = (fill_q != '0);
      fill_v       = '0;
      exp_v        = length_for_type(lengths_q, rx_byte_i[6:4]);
    end
    if (fill_v < exp_v) begin
      buf_d[fill_v[BUF_IDX_W-1:0]] = rx_byte_i;
      fill_v = fill_v + FILL_W'(1);
    end
    if (fill_v == exp_v) begin
      emit_full = (fill_v != '0);
      fill_v    = '0;
      exp_v     = '0;
    end
    fill_d = fill_v;
    exp_d  = exp_v;
  end

  always_comb begin
    rep_partial      = decode_report(buf_q[0], buf_q[1], buf_q[2], buf_q[3]);
    rep_full         = decode_report(buf_d[0], buf_d[1], buf_d[2], buf_d[3]);
    rep_partial.last = ~emit_full;
    rep_full.last    = 1'b1;
    rep_first        = emit_partial ? rep_partial : rep_full;
    push_n           = rx_acc ? QCNT_W'(emit_partial) + QCNT_W'(emit_full) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      exp_q  <= '0;
      for (int i = 0; i < BUFFER_BYTES; i++) begin
        buf_q[i] <= '0;
      end
    end else if (rx_acc) begin
      fill_q <= fill_d;
      exp_q  <= exp_d;
      buf_q  <= buf_d;
    end
  end

  // output queue
  assign count_d = count_q + push_n - QCNT_W'(rpt_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_q + QPTR_W'(push_n);
      rd_ptr_q <= rd_ptr_q + QPTR_W'(rpt_acc);
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_n != '0) begin
      queue_q[wr_ptr_q] <= rep_first;
    end
    if (push_n == QCNT_W'(2)) begin
      queue_q[wr_ptr_q + QPTR_W'(1)] <= rep_full;
    end
  end

  assign rx_stall_o  = (count_q > QCNT_W'(QUEUE_DEPTH - 2));
  assign rpt_valid_o = (count_q != '0);

  always_comb begin
    report_t head;
    head          = queue_q[rd_ptr_q];
    report_kind_o = head.kind;
    buttons_o     = head.buttons;
    stick_x_o     = head.stick_x;
    stick_y_o     = head.stick_y;
    throttle_o    = head.throttle;
    hat_x_o       = head.hat_x;
    hat_y_o       = head.hat_y;
    dial_delta_o  = head.dial_delta;
    last_of_run_o = head.last;
  end

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= QCNT_W'(QUEUE_DEPTH))
    else $error("report queue over capacity");

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fill_q == '0) || (fill_q < exp_q))
    else $error("fill index not below expected length");

  a_exp_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    exp_q <= FILL_W'(BUFFER_BYTES))
    else $error("expected length above buffer size");

  a_room_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rx_acc |-> (count_q <= QCNT_W'(QUEUE_DEPTH - 2)))
    else $error("request accepted without room for two reports");

  a_idle_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0 && !rx_acc) |=> (count_q == '0))
    else $error("report appeared without a request");

endmodule

>>> dv/tb_top.sv
// testbench for the joystick serial packet decoder: directed and random byte streams
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import jspd_pkg::*;

  typedef struct packed {
    logic [1:0]        kind;
    logic [3:0]        buttons;
    logic signed [9:0] stick_x;
    logic signed [8:0] stick_y;
    logic signed [8:0] throttle;
    logic signed [1:0] hat_x;
    logic signed [1:0] hat_y;
    logic signed [8:0] dial_delta;
    logic              last;
  } joy_report_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic                  psel = 1'b0;
  logic                  penable = 1'b0;
  logic                  pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  logic       rx_valid_i = 1'b0;
  logic       rx_stall_o;
  logic [7:0] rx_byte_i = 8'h00;

  logic              rpt_valid_o;
  logic              rpt_stall_i = 1'b0;
  logic [1:0]        report_kind_o;
  logic [3:0]        buttons_o;
  logic signed [9:0] stick_x_o;
  logic signed [8:0] stick_y_o;
  logic signed [8:0] throttle_o;
  logic signed [1:0] hat_x_o;
  logic signed [1:0] hat_y_o;
  logic signed [8:0] dial_delta_o;
  logic              last_of_run_o;

  // decoder state as seen by the testbench
  logic [LENGTHS_W-1:0] lengths_reg = LENGTHS_RESET;
  logic [7:0]           pkt_bytes [BUFFER_BYTES] = '{default: 8'h00};
  logic [2:0]           pkt_fill = '0;
  logic [2:0]           pkt_len = '0;

  joy_report_t expected_reports[$];
  int          errors = 0;
  bit          steady = 1'b0;

  joystick_serial_packet_decoder dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .rx_valid_i    (rx_valid_i),
    .rx_stall_o    (rx_stall_o),
    .rx_byte_i     (rx_byte_i),
    .rpt_valid_o   (rpt_valid_o),
    .rpt_stall_i   (rpt_stall_i),
    .report_kind_o (report_kind_o),
    .buttons_o     (buttons_o),
    .stick_x_o     (stick_x_o),
    .stick_y_o     (stick_y_o),
    .throttle_o    (throttle_o),
    .hat_x_o       (hat_x_o),
    .hat_y_o       (hat_y_o),
    .dial_delta_o  (dial_delta_o),
    .last_of_run_o (last_of_run_o)
  );

  always #6 clk_i = ~clk_i;

  always @(negedge clk_i) begin
    rpt_stall_i <= !steady && ($urandom_range(99) < 11);
  end

  function automatic logic [2:0] pkt_length(logic [2:0] ptype);
    logic [2:0] n;
    n = lengths_reg[3*ptype +: 3];
    return (n > BUFFER_BYTES) ? 3'(BUFFER_BYTES) : n;
  endfunction

  // decode whatever the buffer holds, stale bytes included
  function automatic joy_report_t decode_packet();
    joy_report_t r;
    logic [7:0]  b0, b1, b2, b3;
    int          hi1, hi2;
    b0 = pkt_bytes[0];
    b1 = pkt_bytes[1];
    b2 = pkt_bytes[2];
    b3 = pkt_bytes[3];
    hi1 = int'(b1) | (int'(b0[0]) << 7);
    hi2 = int'(b2) | (int'(b0[2]) << 7);
    r = '0;
    r.kind = KIND_EMPTY;
    case (b0[6:4])
      TYPE_BUTTONS: begin
        r.kind = KIND_BUTTONS;
        r.buttons = b3[3:0];
      end
      TYPE_STICK: begin
        r.kind = KIND_STICK;
        r.stick_x = 10'(int'(b0[3]) * 256 - hi2);
        r.stick_y = 9'(hi1 - int'(b0[1]) * 256);
      end
      TYPE_ANALOG: begin
        r.kind = KIND_ANALOG;
        r.throttle = 9'(hi1 - int'(b0[1]) * 256);
        r.hat_x = 2'(int'(b3[1]) - int'(b3[0]));
        r.hat_y = 2'(int'(b3[3]) - int'(b3[2]));
        r.dial_delta = 9'(hi2 - int'(b0[3]) * 256);
      end
      default: begin
        r.kind = KIND_EMPTY;
      end
    endcase
    return r;
  endfunction

  task automatic predict_byte(input logic [7:0] b);
    joy_report_t run [2];
    int          n;
    n = 0;
    if (b[7]) begin
      // a start byte flushes a partial packet first
      if (pkt_fill != 0) begin
        run[n] = decode_packet();
        n++;
      end
      pkt_fill = '0;
      pkt_len = pkt_length(b[6:4]);
    end
    if (pkt_fill < pkt_len && pkt_fill < BUFFER_BYTES) begin
      pkt_bytes[pkt_fill] = b;
      pkt_fill++;
    end
    if (pkt_fill == pkt_len) begin
      if (pkt_fill != 0) begin
        run[n] = decode_packet();
        n++;
      end
      pkt_fill = '0;
      pkt_len = '0;
    end
    if (n > 0) run[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) expected_reports.push_back(run[i]);
  endtask

  task automatic send_byte(input logic [7:0] b);
    @(negedge clk_i);
    while (!steady && $urandom_range(99) < 11) begin
      rx_valid_i <= 1'b0;
      rx_byte_i <= 8'($urandom);
      @(negedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i <= b;
    do @(posedge clk_i); while (rx_stall_o);
    predict_byte(b);
  endtask

  // wait for every pending report, then let the pipeline settle
  task automatic drain();
    int waited;
    @(negedge clk_i);
    rx_valid_i <= 1'b0;
    waited = 0;
    while (expected_reports.size() != 0 && waited < 20000) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_lengths(input logic [LENGTHS_W-1:0] v);
    drain();
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(4 * REG_PACKET_LENGTHS);
    pwdata <= {8'($urandom), v};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    lengths_reg = v;
    // back-to-back read of the same register
    @(negedge clk_i);
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== CFG_DATA_W'(v)) begin
      errors++;
      $display("%0t: packet_lengths readback expected %h got %h", $time, v, prdata);
    end
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // random packets: mostly well formed, some cut short or overlong, some stray bytes
  task automatic run_packets(input int n_items);
    int         sent;
    int         r;
    int         n_data;
    logic [2:0] ptype;
    logic [7:0] b;
    sent = 0;
    while (sent < n_items) begin
      r = $urandom_range(99);
      if (r < 8) begin
        b = {1'b0, 7'($urandom)};
        if (pkt_len != 0) sent++;
        send_byte(b);
      end else begin
        if ($urandom_range(99) < 60) begin
          case ($urandom_range(2))
            0: ptype = TYPE_BUTTONS;
            1: ptype = TYPE_STICK;
            default: ptype = TYPE_ANALOG;
          endcase
        end else begin
          ptype = 3'($urandom);
        end
        n_data = (pkt_length(ptype) > 0) ? pkt_length(ptype) - 1 : 0;
        if (r < 20) n_data = $urandom_range(n_data + 1);
        send_byte({1'b1, ptype, 4'($urandom)});
        sent++;
        repeat (n_data) begin
          b = {1'b0, 7'($urandom)};
          if (pkt_len != 0) sent++;
          send_byte(b);
        end
      end
    end
  endtask

  task automatic check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d got %0d", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : report_check
    joy_report_t want;
    if (rst_ni && rpt_valid_o && !rpt_stall_i) begin
      if (expected_reports.size() == 0) begin
        errors++;
        $display("%0t: unexpected report expected none got kind %0d", $time, report_kind_o);
      end else begin
        want = expected_reports.pop_front();
        check_field("report_kind", want.kind, report_kind_o);
        check_field("buttons", want.buttons, buttons_o);
        check_field("stick_x", $signed(want.stick_x), $signed(stick_x_o));
        check_field("stick_y", $signed(want.stick_y), $signed(stick_y_o));
        check_field("throttle", $signed(want.throttle), $signed(throttle_o));
        check_field("hat_x", $signed(want.hat_x), $signed(hat_x_o));
        check_field("hat_y", $signed(want.hat_y), $signed(hat_y_o));
        check_field("dial_delta", $signed(want.dial_delta), $signed(dial_delta_o));
        check_field("last_of_run", want.last, last_of_run_o);
      end
    end
  end

  task automatic test_basic_packets();
    logic [7:0] seq [] = '{
      8'h05,                          // stray byte while idle
      8'h90, 8'h00, 8'h00, 8'h0F,     // all buttons
      8'hB8, 8'h00, 8'h00,            // stick x at its top
      8'hB7, 8'h7F, 8'h7F,            // stick x at its bottom
      8'hD5, 8'h7F, 8'h7F, 8'h05,     // throttle and dial high, hat -1/-1
      8'hDA, 8'h00, 8'h00, 8'h0A,     // throttle and dial low, hat +1/+1
      8'hB2, 8'h40, 8'hD1, 8'h11,     // partial stick, then partial analog
      8'h80,                          // zero length start flushes the partial one
      8'hF0                           // zero length start while idle
    };
    write_lengths(LENGTHS_RESET);
    foreach (seq[i]) send_byte(seq[i]);
  endtask

  task automatic test_reset_table();
    write_lengths(LENGTHS_RESET);
    run_packets(300);
  endtask

  // lengths of 5..7 must act as the buffer size
  task automatic test_clamped_lengths();
    write_lengths('1);
    run_packets(150);
    write_lengths(24'hBF5FAE);
    run_packets(150);
  endtask

  // every length is one, so a start byte completes its own packet and data bytes are stray
  task automatic test_single_byte_packets();
    write_lengths(24'h249249);
    run_packets(300);
  endtask

  task automatic test_zero_lengths();
    write_lengths('0);
    run_packets(30);
  endtask

  task automatic test_steady_flow();
    write_lengths(LENGTHS_RESET);
    steady = 1'b1;
    run_packets(300);
    drain();
    steady = 1'b0;
  endtask

  task automatic test_random_tables();
    repeat (3) begin
      write_lengths(LENGTHS_W'($urandom));
      run_packets(200);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    test_basic_packets();
    test_reset_table();
    test_clamped_lengths();
    test_single_byte_packets();
    test_zero_lengths();
    test_steady_flow();
    test_random_tables();
    drain();
    if (expected_reports.size() != 0) begin
      errors++;
      $display("%0t: %0d reports expected but never arrived", $time, expected_reports.size());
    end
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("FAIL");
    $finish;
  end

endmodule

>>> sim.f
rtl/jspd_pkg.sv
rtl/joystick_serial_packet_decoder.sv
dv/tb_top.sv
